// File: rtl/pcc_pkg.sv
package pcc_pkg;

  // Default sizing of the tag store.
  localparam int SLOTS_DEF     = 16;
  localparam int PAGE_BITS_DEF = 20;

  // Configuration port sizing.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int ENTRIES_W  = 5;
  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACEMENT_MODE = 1'b0,
    CFG_ENTRIES_IN_USE   = 1'b1
  } cfg_index_t;

  // Input action codes.
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // Replacement policy codes.
  localparam logic MODE_CLOCK  = 1'b0;
  localparam logic MODE_CLOCKM = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_MISS,
    S_VSCAN,
    S_VREAD,
    S_VDATA,
    S_FLCHK,
    S_FLREAD,
    S_RESP
  } state_t;

  // Tag memory port controls.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tag_ctl_t;

endpackage

// File: rtl/page_cache_clock_replacement.sv
// Fully associative page tag store with clock or enhanced clock replacement.
// Page tags live in a single-port-read synchronous memory that is read one
// slot per cycle, so the read port sets the pace. An access scans the active
// slots for a hit and records the first free slot; a miss fills that free
// slot, or else walks the clock hand to pick a victim, which is read back and
// overwritten. A flush steps through the slots up to the last dirty one and
// reports each dirty slot in turn, then clears all slots. One item is worked
// on at a time; a finished result waits in the output register while the next
// one is built.
module page_cache_clock_replacement #(
  parameter int SLOTS     = pcc_pkg::SLOTS_DEF,
  parameter int PAGE_BITS = pcc_pkg::PAGE_BITS_DEF,
  localparam int SLOT_W   = $clog2(SLOTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [PAGE_BITS-1:0]          page_number,
  input  logic                          is_write,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [SLOT_W-1:0]             slot,
  output logic                          victim_valid,
  output logic [PAGE_BITS-1:0]          victim_page,
  output logic                          write_back,
  output logic                          last
);
  import pcc_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t state, state_next, ret_state;

  logic                 mode;
  logic [ENTRIES_W-1:0] entries;
  logic [SLOTS-1:0]     valid_bits, use_bits, dirty_bits;
  logic [SLOT_W-1:0]    hand;

  logic [PAGE_BITS-1:0] page_r;
  logic                 wr_r;
  logic [CNT_W-1:0]     scan;
  logic                 rvalid;
  logic [SLOT_W-1:0]    ridx;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    cur, start_r, k, victim, fidx;
  logic [1:0]           phase;

  logic                 res_hit, res_vv, res_wb, res_last;
  logic [SLOT_W-1:0]    res_slot;
  logic [PAGE_BITS-1:0] res_vpage;

  tag_ctl_t             tctl;
  logic [SLOT_W-1:0]    rd_addr, wr_addr;
  logic [PAGE_BITS-1:0] tag_q;
  logic                 match;

  logic [CNT_W-1:0]     n_act;
  logic [SLOT_W-1:0]    n_last;
  logic [SLOTS-1:0]     vd;
  logic                 look_hit, look_miss, issue;
  logic                 pick, step_end, vscan_done;
  logic [SLOT_W-1:0]    cur_next, victim_next;
  logic                 flush_last, out_free;

  // Tag memory.
  pcc_tag_store #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_tags (
    .clk      (clk),
    .ctl      (tctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (page_r),
    .cmp_page (page_r),
    .rd_data  (tag_q),
    .match    (match)
  );

  // Active slot count, clamped to one through SLOTS.
  always_comb begin
    if (32'(entries) > SLOTS) begin
      n_act = CNT_W'(SLOTS);
    end else if (entries == '0) begin
      n_act = CNT_W'(1);
    end else begin
      n_act = CNT_W'(entries);
    end
    n_last = SLOT_W'(n_act - CNT_W'(1));
  end

  // Lookup, victim search and flush decisions.
  always_comb begin
    vd         = valid_bits & dirty_bits;
    look_hit   = rvalid && valid_bits[ridx] && match;
    look_miss  = !rvalid && (scan == n_act);
    issue      = (state == S_LOOK) && (scan != n_act) && !look_hit;
    step_end   = (k == n_last);
    cur_next   = (cur == n_last) ? '0 : cur + SLOT_W'(1);
    if (mode == MODE_CLOCKM) begin
      pick = phase[0] ? (!use_bits[cur] && dirty_bits[cur])
                      : (!use_bits[cur] && !dirty_bits[cur]);
    end else begin
      pick = !use_bits[cur];
    end
    vscan_done  = pick || ((mode == MODE_CLOCKM) && (phase == 2'd3) && step_end);
    victim_next = pick ? cur : start_r;
    flush_last  = 1'b1;
    for (int j = 0; j < SLOTS; j++) begin
      if ((j > int'(fidx)) && vd[j]) begin
        flush_last = 1'b0;
      end
    end
    out_free = !out_valid || !out_stall;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_FLUSH) begin
            state_next = (|vd) ? S_FLCHK : S_RESP;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (look_hit) begin
          state_next = S_RESP;
        end else if (look_miss) begin
          state_next = S_MISS;
        end
      end
      S_MISS:   state_next = free_found ? S_RESP : S_VSCAN;
      S_VSCAN: begin
        if (vscan_done) begin
          state_next = S_VREAD;
        end
      end
      S_VREAD:  state_next = S_VDATA;
      S_VDATA:  state_next = S_RESP;
      S_FLCHK: begin
        if (vd[fidx]) begin
          state_next = S_FLREAD;
        end
      end
      S_FLREAD: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = ret_state;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake and tag memory controls.
  always_comb begin
    in_stall   = (state != S_IDLE);
    tctl.rd_en = issue || (state == S_VREAD) || ((state == S_FLCHK) && vd[fidx]);
    tctl.wr_en = ((state == S_MISS) && free_found) || (state == S_VDATA);
    unique case (state)
      S_VREAD: rd_addr = victim;
      S_FLCHK: rd_addr = fidx;
      default: rd_addr = scan[SLOT_W-1:0];
    endcase
    wr_addr = (state == S_VDATA) ? victim : free_idx;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      mode       <= MODE_CLOCK;
      entries    <= ENTRIES_RESET;
      valid_bits <= '0;
      use_bits   <= '0;
      dirty_bits <= '0;
      hand       <= '0;
      out_valid  <= 1'b0;
      rvalid     <= 1'b0;
      free_found <= 1'b0;
      scan       <= '0;
      phase      <= '0;
    end else begin
      state  <= state_next;
      rvalid <= issue;
      if (issue) begin
        scan <= scan + CNT_W'(1);
      end

      // Configuration writes.
      if (cfg_write_en) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_REPLACEMENT_MODE: mode    <= cfg_data[0];
          CFG_ENTRIES_IN_USE:   entries <= cfg_data;
          default:              mode    <= mode;
        endcase
      end

      // Output register transfer.
      if ((state == S_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan       <= '0;
            free_found <= 1'b0;
            ret_state  <= S_IDLE;
            if ((action == ACT_FLUSH) && !(|vd)) begin
              valid_bits <= '0;
              use_bits   <= '0;
              dirty_bits <= '0;
            end
          end
        end
        S_LOOK: begin
          if (look_hit) begin
            use_bits[ridx]   <= 1'b1;
            dirty_bits[ridx] <= dirty_bits[ridx] | wr_r;
          end else if (rvalid && !valid_bits[ridx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
        S_MISS: begin
          phase <= '0;
          if (free_found) begin
            valid_bits[free_idx] <= 1'b1;
            use_bits[free_idx]   <= 1'b1;
            dirty_bits[free_idx] <= wr_r;
          end
        end
        S_VSCAN: begin
          if (!vscan_done) begin
            if ((mode == MODE_CLOCK) || phase[0]) begin
              use_bits[cur] <= 1'b0;
            end
            if ((mode == MODE_CLOCKM) && step_end) begin
              phase <= phase + 2'd1;
            end
          end
        end
        S_VDATA: begin
          valid_bits[victim] <= 1'b1;
          use_bits[victim]   <= 1'b1;
          dirty_bits[victim] <= wr_r;
          hand <= (victim == n_last) ? '0 : victim + SLOT_W'(1);
        end
        S_FLREAD: begin
          if (flush_last) begin
            ret_state  <= S_IDLE;
            valid_bits <= '0;
            use_bits   <= '0;
            dirty_bits <= '0;
          end else begin
            ret_state <= S_FLCHK;
          end
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

  // Payload and scan position registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      ridx <= scan[SLOT_W-1:0];
    end
    unique case (state)
      S_IDLE: begin
        page_r    <= page_number;
        wr_r      <= is_write;
        fidx      <= '0;
        res_hit   <= 1'b0;
        res_slot  <= '0;
        res_vv    <= 1'b0;
        res_vpage <= '0;
        res_wb    <= 1'b0;
        res_last  <= 1'b1;
      end
      S_LOOK: begin
        if (look_hit) begin
          res_hit  <= 1'b1;
          res_slot <= ridx;
        end else if (rvalid && !valid_bits[ridx] && !free_found) begin
          free_idx <= ridx;
        end
      end
      S_MISS: begin
        res_slot <= free_idx;
        start_r  <= (CNT_W'(hand) < n_act) ? hand : '0;
        cur      <= (CNT_W'(hand) < n_act) ? hand : '0;
        k        <= '0;
      end
      S_VSCAN: begin
        if (vscan_done) begin
          victim <= victim_next;
        end else if ((mode == MODE_CLOCKM) && step_end) begin
          cur <= start_r;
          k   <= '0;
        end else begin
          cur <= cur_next;
          k   <= k + SLOT_W'(1);
        end
      end
      S_VDATA: begin
        res_slot  <= victim;
        res_vv    <= 1'b1;
        res_vpage <= tag_q;
        res_wb    <= dirty_bits[victim];
      end
      S_FLCHK: begin
        if (!vd[fidx]) begin
          fidx <= fidx + SLOT_W'(1);
        end
      end
      S_FLREAD: begin
        res_slot  <= fidx;
        res_vv    <= 1'b1;
        res_vpage <= tag_q;
        res_wb    <= 1'b1;
        res_last  <= flush_last;
        fidx      <= fidx + SLOT_W'(1);
      end
      default: begin
        res_hit <= res_hit;
      end
    endcase

    // Load the output register with the finished result.
    if ((state == S_RESP) && out_free) begin
      hit          <= res_hit;
      slot         <= res_slot;
      victim_valid <= res_vv;
      victim_page  <= res_vpage;
      write_back   <= res_wb;
      last         <= res_last;
    end
  end

`ifndef SYNTHESIS
  // A free slot found during lookup stays free until it is filled.
  a_free_slot_free: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOOK) && free_found) |-> !valid_bits[free_idx])
    else $error("recorded free slot is valid");

  // The flush scan only runs while a dirty valid slot remains.
  a_flush_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLCHK) |-> (|vd))
    else $error("flush scan with no dirty slot left");

  // After an eviction the hand stays within the active slots.
  a_hand_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_VDATA) |=> (CNT_W'(hand) < n_act))
    else $error("clock hand beyond active slots");

  // An eviction moves on to the response with the victim marked valid.
  a_resp_from_decision: assert property (@(posedge clk) disable iff (rst)
    (state == S_VDATA) |=> (state == S_RESP) && res_vv)
    else $error("eviction result not marked as victim");
`endif

endmodule

// File: rtl/pcc_tag_store.sv
module pcc_tag_store #(
  parameter int SLOTS     = pcc_pkg::SLOTS_DEF,
  parameter int PAGE_BITS = pcc_pkg::PAGE_BITS_DEF,
  localparam int SLOT_W   = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  pcc_pkg::tag_ctl_t    ctl,
  input  logic [SLOT_W-1:0]    rd_addr,
  input  logic [SLOT_W-1:0]    wr_addr,
  input  logic [PAGE_BITS-1:0] wr_data,
  input  logic [PAGE_BITS-1:0] cmp_page,
  output logic [PAGE_BITS-1:0] rd_data,
  output logic                 match
);
  import pcc_pkg::*;

  logic [PAGE_BITS-1:0] mem [SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Compare the tag just read against the page being looked up.
  assign match = (rd_data == cmp_page);

endmodule
